/* rtl/core/eeg_headset_packet_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// eeg headset packet parser assertion macros
// shared concurrent assertion forms for the parser core
// ----------------------------------------------------------------------------
`ifndef EEG_HEADSET_PACKET_PARSER_CORE_MACROS_SVH
`define EEG_HEADSET_PACKET_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define EEG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define EEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/core/eeg_pkt_pkg.sv */
// ----------------------------------------------------------------------------
// eeg packet parser package
// phases, row codes, status codes and decode helpers for the parser core
// ----------------------------------------------------------------------------
package eeg_pkt_pkg;

   localparam int unsigned KIND_COUNT = 13;

   localparam logic [7:0] SYNC_BYTE       = 8'hAA;
   localparam logic [7:0] MAX_PAYLOAD_LEN = 8'd169;
   localparam logic [7:0] CODE_EXTENDED   = 8'h80;
   localparam logic [7:0] CODE_RAW        = 8'h80;
   localparam logic [7:0] CODE_BANDS      = 8'h83;
   localparam logic [7:0] CODE_SKIP       = 8'hFF;
   localparam logic [7:0] LEN_RAW         = 8'h02;
   localparam logic [7:0] LEN_BANDS       = 8'h18;
   localparam logic [7:0] CODE_POWER      = 8'h01;
   localparam logic [7:0] CODE_SIGNAL     = 8'h02;
   localparam logic [7:0] CODE_ATTENTION  = 8'h04;
   localparam logic [7:0] CODE_MEDITATION = 8'h05;

   localparam logic [3:0] KIND_POWER      = 4'd0;
   localparam logic [3:0] KIND_SIGNAL     = 4'd1;
   localparam logic [3:0] KIND_ATTENTION  = 4'd2;
   localparam logic [3:0] KIND_MEDITATION = 4'd3;
   localparam logic [3:0] KIND_RAW        = 4'd4;
   localparam logic [3:0] KIND_DELTA      = 4'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CHECK = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_LEN,
      PH_CODE,
      PH_ROWLEN,
      PH_ROWDATA,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] kind;
   } kind_hit_type;

   typedef struct packed {
      logic                  hold_en;
      logic [3:0]            hold_kind;
      logic [23:0]           hold_value;
      logic                  check_en;
      logic                  check_ok;
      logic [KIND_COUNT-1:0] present;
   } parse_event_type;

   function automatic kind_hit_type single_kind(input logic [7:0] code);
      kind_hit_type r;
      r.hit  = 1'b1;
      r.kind = KIND_POWER;
      unique case (code)
         CODE_POWER:      r.kind = KIND_POWER;
         CODE_SIGNAL:     r.kind = KIND_SIGNAL;
         CODE_ATTENTION:  r.kind = KIND_ATTENTION;
         CODE_MEDITATION: r.kind = KIND_MEDITATION;
         default:         r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   // bytes left after a band value completes, first band has 21 left
   function automatic kind_hit_type band_kind(input logic [7:0] left);
      kind_hit_type r;
      r.hit  = 1'b1;
      r.kind = KIND_DELTA;
      unique case (left)
         8'd21:   r.kind = KIND_DELTA;
         8'd18:   r.kind = KIND_DELTA + 4'd1;
         8'd15:   r.kind = KIND_DELTA + 4'd2;
         8'd12:   r.kind = KIND_DELTA + 4'd3;
         8'd9:    r.kind = KIND_DELTA + 4'd4;
         8'd6:    r.kind = KIND_DELTA + 4'd5;
         8'd3:    r.kind = KIND_DELTA + 4'd6;
         8'd0:    r.kind = KIND_DELTA + 4'd7;
         default: r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] lowest_set(input logic [KIND_COUNT-1:0] mask);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = KIND_COUNT - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/core/eeg_headset_packet_parser_core.sv */
// ----------------------------------------------------------------------------
// eeg headset packet parser core
// framed serial packet parser with per-packet result burst
// ----------------------------------------------------------------------------
// req channel carries one received serial byte per word. a byte is taken every
// cycle while framing or decoding outside a burst, and while an earlier result
// still waits on rsp; only the checksum byte needs the result register free.
// on a good checksum the held values go out on rsp in kind order, one word per
// unstalled cycle, tlast on the final one; a bad checksum or a packet with
// no known values gives one word with a status in tuser and tlast set.
// a status word appears in the cycle after the checksum byte; the first value
// word is registered in the drain mask and then the output register. values
// go out one at a time via the single read port of the held value store and
// req_tready is low meanwhile; a stalled rsp_tready holds the current word and
// pauses the burst. reset (synchronous) returns to hunting the first sync byte,
// drops any burst in flight and clears rsp_tvalid.
// ----------------------------------------------------------------------------
`include "eeg_headset_packet_parser_core_macros.svh"

module eeg_headset_packet_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // value_data
   output logic [5:0]  rsp_tuser,   // value_kind [3:0], packet_status [5:4]
   output logic        rsp_tlast    // last_of_packet
);

   localparam int unsigned KC = eeg_pkt_pkg::KIND_COUNT;

   eeg_pkt_pkg::parse_event_type ev;
   logic in_check;
   logic accept;
   logic out_free;

   logic [23:0] held_ff [KC];
   logic [KC-1:0] drain_ff, drain_in;
   logic [KC-1:0] drain_rest;
   logic [3:0]    drain_idx;

   logic        valid_ff, valid_in;
   logic [3:0]  kind_ff, kind_in;
   logic [23:0] data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (drain_ff == '0) && (!in_check || out_free);
   assign accept     = req_tvalid && req_tready;
   assign drain_idx  = eeg_pkt_pkg::lowest_set(drain_ff);
   assign drain_rest = drain_ff & (drain_ff - KC'(1));

   eeg_pkt_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .data_byte  (req_tdata),
      .in_check   (in_check),
      .ev         (ev)
   );

   always_ff @(posedge clock) begin
      if (ev.hold_en) begin
         held_ff[ev.hold_kind] <= ev.hold_value;
      end
   end

   always_comb begin
      drain_in  = drain_ff;
      valid_in  = valid_ff && !rsp_tready;
      kind_in   = kind_ff;
      data_in   = data_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (ev.check_en) begin
         if (!ev.check_ok || ev.present == '0) begin
            valid_in  = 1'b1;
            kind_in   = 4'd0;
            data_in   = 24'd0;
            status_in = ev.check_ok ? eeg_pkt_pkg::STATUS_EMPTY : eeg_pkt_pkg::STATUS_CHECK;
            last_in   = 1'b1;
         end else begin
            drain_in = ev.present;
         end
      end else if (drain_ff != '0 && out_free) begin
         valid_in  = 1'b1;
         kind_in   = drain_idx;
         data_in   = held_ff[drain_idx];
         status_in = eeg_pkt_pkg::STATUS_OK;
         last_in   = (drain_rest == '0);
         drain_in  = drain_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         drain_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {status_ff, kind_ff};
   assign rsp_tlast  = last_ff;

   `EEG_ASSERT_IMPLY(a_no_req_in_burst, clock, reset, drain_ff != '0, !req_tready)
   `EEG_ASSERT_NEXT(a_burst_moves, clock, reset, drain_ff != '0 && out_free, rsp_tvalid)
   `EEG_ASSERT_IMPLY(a_status_is_last, clock, reset,
      rsp_tvalid && rsp_tuser[5:4] != eeg_pkt_pkg::STATUS_OK, rsp_tlast)
   `EEG_ASSERT_NEXT(a_bad_sum_word, clock, reset, ev.check_en && !ev.check_ok,
      rsp_tvalid && rsp_tuser[5:4] == eeg_pkt_pkg::STATUS_CHECK)

endmodule

/* rtl/core/eeg_pkt_parser.sv */
// ----------------------------------------------------------------------------
// eeg packet parser framing and row decode
// sync hunt, length check, payload sum and row decode, one byte per valid cycle
// ----------------------------------------------------------------------------
module eeg_pkt_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_valid,
   input  logic [7:0]                data_byte,
   output logic                      in_check,
   output eeg_pkt_pkg::parse_event_type ev
);

   eeg_pkt_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  left_ff, left_in;
   logic [23:0] acc_ff, acc_in;
   logic [eeg_pkt_pkg::KIND_COUNT-1:0] present_ff, present_in;

   logic [7:0]  count_next;
   logic [7:0]  left_dec;
   logic [23:0] acc_shift;
   logic        len_bad;
   eeg_pkt_pkg::kind_hit_type sk;
   eeg_pkt_pkg::kind_hit_type bk;

   assign count_next = count_ff + 8'd1;
   assign left_dec   = left_ff - 8'd1;
   assign acc_shift  = {acc_ff[15:0], data_byte};
   assign len_bad    = (data_byte == 8'd0) || (data_byte > eeg_pkt_pkg::MAX_PAYLOAD_LEN);
   assign sk         = eeg_pkt_pkg::single_kind(code_ff);
   assign bk         = eeg_pkt_pkg::band_kind(left_dec);
   assign in_check   = (phase_ff == eeg_pkt_pkg::PH_CHECK);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         eeg_pkt_pkg::PH_SYNC1: begin
            phase_in = (data_byte == eeg_pkt_pkg::SYNC_BYTE) ?
                       eeg_pkt_pkg::PH_SYNC2 : eeg_pkt_pkg::PH_SYNC1;
         end
         eeg_pkt_pkg::PH_SYNC2: begin
            phase_in = (data_byte == eeg_pkt_pkg::SYNC_BYTE) ?
                       eeg_pkt_pkg::PH_LEN : eeg_pkt_pkg::PH_SYNC1;
         end
         eeg_pkt_pkg::PH_LEN: begin
            phase_in = len_bad ? eeg_pkt_pkg::PH_SYNC1 : eeg_pkt_pkg::PH_CODE;
         end
         eeg_pkt_pkg::PH_CODE: begin
            phase_in = (data_byte < eeg_pkt_pkg::CODE_EXTENDED) ?
                       eeg_pkt_pkg::PH_ROWDATA : eeg_pkt_pkg::PH_ROWLEN;
         end
         eeg_pkt_pkg::PH_ROWLEN: begin
            phase_in = (data_byte == 8'd0) ? eeg_pkt_pkg::PH_CODE : eeg_pkt_pkg::PH_ROWDATA;
         end
         eeg_pkt_pkg::PH_ROWDATA: begin
            phase_in = (left_dec == 8'd0) ? eeg_pkt_pkg::PH_CODE : eeg_pkt_pkg::PH_ROWDATA;
         end
         eeg_pkt_pkg::PH_CHECK: begin
            phase_in = eeg_pkt_pkg::PH_SYNC1;
         end
         default: begin
            phase_in = eeg_pkt_pkg::PH_SYNC1;
         end
      endcase
      if ((phase_ff == eeg_pkt_pkg::PH_CODE || phase_ff == eeg_pkt_pkg::PH_ROWLEN ||
           phase_ff == eeg_pkt_pkg::PH_ROWDATA) && (count_next >= length_ff)) begin
         phase_in = eeg_pkt_pkg::PH_CHECK;
      end
   end

   // datapath and events
   always_comb begin
      length_in     = length_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      code_in       = code_ff;
      left_in       = left_ff;
      acc_in        = acc_ff;
      present_in    = present_ff;
      ev.hold_en    = 1'b0;
      ev.hold_kind  = sk.kind;
      ev.hold_value = acc_shift;
      ev.check_en   = 1'b0;
      ev.check_ok   = ((~sum_ff) == data_byte);
      ev.present    = present_ff;
      unique case (phase_ff)
         eeg_pkt_pkg::PH_LEN: begin
            if (!len_bad) begin
               length_in  = data_byte;
               count_in   = 8'd0;
               sum_in     = 8'd0;
               code_in    = 8'd0;
               left_in    = 8'd0;
               acc_in     = 24'd0;
               present_in = '0;
            end
         end
         eeg_pkt_pkg::PH_CODE: begin
            sum_in   = sum_ff + data_byte;
            count_in = count_next;
            code_in  = data_byte;
            acc_in   = 24'd0;
            if (data_byte < eeg_pkt_pkg::CODE_EXTENDED) begin
               left_in = 8'd1;
            end
         end
         eeg_pkt_pkg::PH_ROWLEN: begin
            sum_in   = sum_ff + data_byte;
            count_in = count_next;
            left_in  = data_byte;
            if ((code_ff == eeg_pkt_pkg::CODE_RAW && data_byte != eeg_pkt_pkg::LEN_RAW) ||
                (code_ff == eeg_pkt_pkg::CODE_BANDS && data_byte != eeg_pkt_pkg::LEN_BANDS)) begin
               code_in = eeg_pkt_pkg::CODE_SKIP;
            end
         end
         eeg_pkt_pkg::PH_ROWDATA: begin
            sum_in   = sum_ff + data_byte;
            count_in = count_next;
            left_in  = left_dec;
            acc_in   = acc_shift;
            if (code_ff < eeg_pkt_pkg::CODE_EXTENDED) begin
               ev.hold_en = byte_valid && (left_dec == 8'd0) && sk.hit;
            end else if (code_ff == eeg_pkt_pkg::CODE_RAW) begin
               ev.hold_en    = byte_valid && (left_dec == 8'd0);
               ev.hold_kind  = eeg_pkt_pkg::KIND_RAW;
               ev.hold_value = {8'd0, acc_shift[15:0]};
            end else if (code_ff == eeg_pkt_pkg::CODE_BANDS) begin
               ev.hold_en   = byte_valid && bk.hit;
               ev.hold_kind = bk.kind;
               if (bk.hit) begin
                  acc_in = 24'd0;
               end
            end
            if (ev.hold_en) begin
               present_in = present_ff | (eeg_pkt_pkg::KIND_COUNT'(1) << ev.hold_kind);
            end
         end
         eeg_pkt_pkg::PH_CHECK: begin
            ev.check_en = byte_valid;
            present_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= eeg_pkt_pkg::PH_SYNC1;
         length_ff  <= 8'd0;
         count_ff   <= 8'd0;
         sum_ff     <= 8'd0;
         code_ff    <= 8'd0;
         left_ff    <= 8'd0;
         acc_ff     <= 24'd0;
         present_ff <= '0;
      end else if (byte_valid) begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         code_ff    <= code_in;
         left_ff    <= left_in;
         acc_ff     <= acc_in;
         present_ff <= present_in;
      end
   end

endmodule
